[rtl/ssp_pkg.sv]
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared constants, types and helpers of the scan sector proximity classifier.
// ----------------------------------------------------------------------------
package ssp_pkg;

   localparam int RAY_COUNT = 72;
   localparam int OBS_SIZE  = 84;

   localparam int INDEX_W     = 7;
   localparam int VALUE_W     = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int THRESH_W    = 15;
   localparam int GOAL_SQ_W   = 2 * THRESH_W;
   localparam int SCALED_W    = 22;
   localparam int RANGE_W     = 26;
   localparam int GOAL_SUM_W  = 35;

   localparam logic [INDEX_W-1:0] IDX_GOAL_X  = 7'd78;
   localparam logic [INDEX_W-1:0] IDX_GOAL_Y  = 7'd79;
   localparam logic [INDEX_W-1:0] IDX_LINEAR  = 7'd82;
   localparam logic [INDEX_W-1:0] IDX_ANGULAR = 7'd83;

   typedef logic signed [RANGE_W-1:0] range_type;

   // Ranges are kept as 100 * d: 595 * v + 20480 + 50 (rounding bias).
   localparam range_type RANGE_GAIN  = 26'sd595;
   localparam range_type RANGE_BIAS  = 26'sd20530;
   localparam int        RANGE_SCALE = 100;
   // floor(MIN_RESET / 100) is the empty-sector value 32767
   localparam range_type MIN_RESET   = 26'sd3276700;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STRAIGHT_MIN_LINEAR  = 3'd0,
      CSR_STRAIGHT_MAX_ANGULAR = 3'd1,
      CSR_TURN_MIN_ANGULAR     = 3'd2,
      CSR_NEAR_GOAL_DISTANCE   = 3'd3,
      CSR_NEAR_OBSTACLE        = 3'd4,
      CSR_BILATERAL_OBSTACLE   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] straight_min_linear;
      logic [THRESH_W-1:0]       straight_max_angular;
      logic [THRESH_W-1:0]       turn_min_angular;
      logic [GOAL_SQ_W-1:0]      near_goal_sq;
      logic [SCALED_W-1:0]       near_obstacle_scaled;
      logic [SCALED_W-1:0]       bilateral_scaled;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      straight_min_linear:  16'sd819,
      straight_max_angular: 15'd819,
      turn_min_angular:     15'd1638,
      near_goal_sq:         30'd4194304,
      near_obstacle_scaled: 22'd204800,
      bilateral_scaled:     22'd307200
   };

   typedef struct packed {
      logic [INDEX_W-1:0]        index;
      logic signed [VALUE_W-1:0] value;
      range_type                 range;
      logic                      front;
      logic                      left;
      logic                      right;
      logic                      last;
   } stage_type;

   typedef struct packed {
      logic straight;
      logic turning_left;
      logic turning_right;
      logic goal_close;
      logic front_blocked;
      logic left_blocked;
      logic right_blocked;
      logic both_sides_blocked;
   } flags_type;

   // Ray i sits at -180 + 360*i/RAY_COUNT degrees; bounds are inclusive.
   function automatic logic in_front(logic [INDEX_W-1:0] idx);
      int i;
      int off;
      i   = int'(idx);
      off = 12 * i - 6 * RAY_COUNT;
      if (off < 0) begin
         off = -off;
      end
      return (i < RAY_COUNT) && (off <= RAY_COUNT);
   endfunction

   function automatic logic in_left(logic [INDEX_W-1:0] idx);
      int i;
      i = int'(idx);
      return (i < RAY_COUNT) && (36 * i >= 21 * RAY_COUNT) && (36 * i <= 28 * RAY_COUNT);
   endfunction

   function automatic logic in_right(logic [INDEX_W-1:0] idx);
      int i;
      i = int'(idx);
      return (i < RAY_COUNT) && (36 * i >= 8 * RAY_COUNT) && (36 * i <= 15 * RAY_COUNT);
   endfunction

endpackage

[rtl/ssp_req_if.sv]
// ----------------------------------------------------------------------------
// ssp_req_if
// Observation element channel: valid/ready with index, value and last mark.
// ----------------------------------------------------------------------------
interface ssp_req_if;
   logic                               valid;
   logic                               ready;
   logic [ssp_pkg::INDEX_W-1:0]        element_index;
   logic signed [ssp_pkg::VALUE_W-1:0] element_value;
   logic                               last_element;

   modport source (output valid, element_index, element_value, last_element,
                   input ready);
   modport sink   (input valid, element_index, element_value, last_element,
                   output ready);
endinterface

[rtl/ssp_rsp_if.sv]
// ----------------------------------------------------------------------------
// ssp_rsp_if
// Classification result channel: valid/ready with eight flags.
// ----------------------------------------------------------------------------
interface ssp_rsp_if;
   logic valid;
   logic ready;
   logic straight;
   logic turning_left;
   logic turning_right;
   logic goal_close;
   logic front_blocked;
   logic left_blocked;
   logic right_blocked;
   logic both_sides_blocked;

   modport source (output valid, straight, turning_left, turning_right, goal_close,
                   front_blocked, left_blocked, right_blocked, both_sides_blocked,
                   input ready);
   modport sink   (input valid, straight, turning_left, turning_right, goal_close,
                   front_blocked, left_blocked, right_blocked, both_sides_blocked,
                   output ready);
endinterface

[rtl/ssp_csr.sv]
// ----------------------------------------------------------------------------
// ssp_csr
// Threshold registers; obstacle thresholds are stored scaled by 100 and the
// goal threshold squared, so the datapath compares directly.
// ----------------------------------------------------------------------------
module ssp_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [ssp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ssp_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output ssp_pkg::cfg_type                   cfg
);

   ssp_pkg::cfg_type             cfg_ff;
   ssp_pkg::cfg_type             cfg_in;
   logic [ssp_pkg::THRESH_W-1:0] thresh;

   assign thresh = csr_write_data[ssp_pkg::THRESH_W-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (ssp_pkg::csr_index_type'(csr_index))
            ssp_pkg::CSR_STRAIGHT_MIN_LINEAR: begin
               cfg_in.straight_min_linear = $signed(csr_write_data);
            end
            ssp_pkg::CSR_STRAIGHT_MAX_ANGULAR: begin
               cfg_in.straight_max_angular = thresh;
            end
            ssp_pkg::CSR_TURN_MIN_ANGULAR: begin
               cfg_in.turn_min_angular = thresh;
            end
            ssp_pkg::CSR_NEAR_GOAL_DISTANCE: begin
               cfg_in.near_goal_sq = ssp_pkg::GOAL_SQ_W'(thresh) *
                                     ssp_pkg::GOAL_SQ_W'(thresh);
            end
            ssp_pkg::CSR_NEAR_OBSTACLE: begin
               cfg_in.near_obstacle_scaled = ssp_pkg::SCALED_W'(thresh) *
                                             ssp_pkg::SCALED_W'(ssp_pkg::RANGE_SCALE);
            end
            ssp_pkg::CSR_BILATERAL_OBSTACLE: begin
               cfg_in.bilateral_scaled = ssp_pkg::SCALED_W'(thresh) *
                                         ssp_pkg::SCALED_W'(ssp_pkg::RANGE_SCALE);
            end
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= ssp_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/ssp_input_stage.sv]
// ----------------------------------------------------------------------------
// ssp_input_stage
// Input register: captures an element with its scaled range and sector hits.
// ----------------------------------------------------------------------------
module ssp_input_stage (
   input  logic               clock,
   input  logic               reset,
   ssp_req_if.sink            req,
   input  logic               stage_ready,
   output logic               stage_valid,
   output ssp_pkg::stage_type stage
);

   logic               valid_ff;
   ssp_pkg::stage_type stage_ff;
   ssp_pkg::stage_type stage_in;
   logic               accept;

   assign req.ready = !valid_ff || stage_ready;
   assign accept    = req.valid && req.ready;

   always_comb begin
      stage_in.index = req.element_index;
      stage_in.value = req.element_value;
      // 100 * range before rounding down
      stage_in.range = ssp_pkg::RANGE_GAIN * ssp_pkg::range_type'(req.element_value) +
                       ssp_pkg::RANGE_BIAS;
      stage_in.front = ssp_pkg::in_front(req.element_index);
      stage_in.left  = ssp_pkg::in_left(req.element_index);
      stage_in.right = ssp_pkg::in_right(req.element_index);
      stage_in.last  = req.last_element;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (accept) begin
         valid_ff <= 1'b1;
      end else if (stage_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage       = stage_ff;

endmodule

[rtl/ssp_classify.sv]
// ----------------------------------------------------------------------------
// ssp_classify
// Sector minima, latched speeds and goal vector, flag logic and the result
// register.
// ----------------------------------------------------------------------------
module ssp_classify (
   input  logic               clock,
   input  logic               reset,
   input  ssp_pkg::cfg_type   cfg,
   input  logic               stage_valid,
   input  ssp_pkg::stage_type stage,
   output logic               stage_ready,
   ssp_rsp_if.source          rsp
);

   ssp_pkg::range_type front_min_ff, left_min_ff, right_min_ff;
   ssp_pkg::range_type front_min_in, left_min_in, right_min_in;

   logic signed [ssp_pkg::VALUE_W-1:0] linear_ff, angular_ff, goal_x_ff, goal_y_ff;
   logic signed [ssp_pkg::VALUE_W-1:0] linear_in, angular_in, goal_x_in, goal_y_in;

   logic                rsp_valid_ff;
   ssp_pkg::flags_type  flags_ff;
   ssp_pkg::flags_type  flags_in;

   logic advance;
   logic is_ray;
   logic is_latch;

   logic signed [ssp_pkg::VALUE_W+1:0]    lin_floor;
   logic signed [ssp_pkg::VALUE_W+1:0]    lin_ext;
   logic signed [ssp_pkg::VALUE_W:0]      ang_ext;
   logic [ssp_pkg::VALUE_W:0]             ang_abs;
   logic signed [ssp_pkg::VALUE_W:0]      turn_pos;
   logic signed [ssp_pkg::VALUE_W:0]      turn_neg;
   logic signed [2*ssp_pkg::VALUE_W-1:0]  gx_sq, gy_sq;
   logic [ssp_pkg::GOAL_SUM_W-1:0]        g_sum, g_scaled;
   ssp_pkg::range_type                    near_lim, bil_lim;

   // a last element must find the result register free
   assign stage_ready = !stage.last || !rsp_valid_ff || rsp.ready;
   assign advance     = stage_valid && stage_ready;

   assign is_ray   = int'(stage.index) < ssp_pkg::RAY_COUNT;
   assign is_latch = !is_ray && (int'(stage.index) < ssp_pkg::OBS_SIZE);

   always_comb begin
      front_min_in = (stage.front && stage.range < front_min_ff) ? stage.range : front_min_ff;
      left_min_in  = (stage.left  && stage.range < left_min_ff)  ? stage.range : left_min_ff;
      right_min_in = (stage.right && stage.range < right_min_ff) ? stage.range : right_min_ff;

      goal_x_in  = (is_latch && stage.index == ssp_pkg::IDX_GOAL_X)  ? stage.value : goal_x_ff;
      goal_y_in  = (is_latch && stage.index == ssp_pkg::IDX_GOAL_Y)  ? stage.value : goal_y_ff;
      linear_in  = (is_latch && stage.index == ssp_pkg::IDX_LINEAR)  ? stage.value : linear_ff;
      angular_in = (is_latch && stage.index == ssp_pkg::IDX_ANGULAR) ? stage.value : angular_ff;
   end

   always_comb begin
      // speed is a quarter of the raw value: compare raw against 4x threshold
      lin_floor = $signed({cfg.straight_min_linear, 2'b00});
      lin_ext   = (ssp_pkg::VALUE_W+2)'(linear_in);
      ang_ext   = (ssp_pkg::VALUE_W+1)'(angular_in);
      ang_abs   = angular_in[ssp_pkg::VALUE_W-1] ? ((ssp_pkg::VALUE_W+1)'(0) - ang_ext)
                                                 : ang_ext;
      turn_pos  = $signed({2'b00, cfg.turn_min_angular});
      turn_neg  = -turn_pos;

      gx_sq    = goal_x_in * goal_x_in;
      gy_sq    = goal_y_in * goal_y_in;
      g_sum    = ssp_pkg::GOAL_SUM_W'(gx_sq[2*ssp_pkg::VALUE_W-2:0]) +
                 ssp_pkg::GOAL_SUM_W'(gy_sq[2*ssp_pkg::VALUE_W-2:0]);
      g_scaled = (g_sum << 3) + g_sum;

      // floor(m/100) < t holds exactly when m < 100*t
      near_lim = ssp_pkg::range_type'(cfg.near_obstacle_scaled);
      bil_lim  = ssp_pkg::range_type'(cfg.bilateral_scaled);

      flags_in.straight           = (lin_ext >= lin_floor) &&
                                    (ang_abs <= (ssp_pkg::VALUE_W+1)'(cfg.straight_max_angular));
      flags_in.turning_left       = ang_ext >= turn_pos;
      flags_in.turning_right      = ang_ext <= turn_neg;
      flags_in.goal_close         = g_scaled <= ssp_pkg::GOAL_SUM_W'(cfg.near_goal_sq);
      flags_in.front_blocked      = front_min_in < near_lim;
      flags_in.left_blocked       = left_min_in < near_lim;
      flags_in.right_blocked      = right_min_in < near_lim;
      flags_in.both_sides_blocked = (left_min_in < bil_lim) && (right_min_in < bil_lim);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_min_ff <= ssp_pkg::MIN_RESET;
         left_min_ff  <= ssp_pkg::MIN_RESET;
         right_min_ff <= ssp_pkg::MIN_RESET;
         linear_ff    <= '0;
         angular_ff   <= '0;
         goal_x_ff    <= '0;
         goal_y_ff    <= '0;
      end else if (advance) begin
         front_min_ff <= stage.last ? ssp_pkg::MIN_RESET : front_min_in;
         left_min_ff  <= stage.last ? ssp_pkg::MIN_RESET : left_min_in;
         right_min_ff <= stage.last ? ssp_pkg::MIN_RESET : right_min_in;
         linear_ff    <= linear_in;
         angular_ff   <= angular_in;
         goal_x_ff    <= goal_x_in;
         goal_y_ff    <= goal_y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && stage.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && stage.last) begin
         flags_ff <= flags_in;
      end
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.straight           = flags_ff.straight;
   assign rsp.turning_left       = flags_ff.turning_left;
   assign rsp.turning_right      = flags_ff.turning_right;
   assign rsp.goal_close         = flags_ff.goal_close;
   assign rsp.front_blocked      = flags_ff.front_blocked;
   assign rsp.left_blocked       = flags_ff.left_blocked;
   assign rsp.right_blocked      = flags_ff.right_blocked;
   assign rsp.both_sides_blocked = flags_ff.both_sides_blocked;

   a_minima_cleared: assert property (@(posedge clock) disable iff (reset)
      advance && stage.last |=> front_min_ff == ssp_pkg::MIN_RESET &&
                                left_min_ff == ssp_pkg::MIN_RESET &&
                                right_min_ff == ssp_pkg::MIN_RESET)
      else $error("sector minima not cleared after last element");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready && stage_valid && stage.last |-> !stage_ready)
      else $error("pending result would be overwritten");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !$past(rsp_valid_ff) |-> $past(advance && stage.last))
      else $error("result raised without a last element");

   a_minima_bound: assert property (@(posedge clock) disable iff (reset)
      front_min_ff <= ssp_pkg::MIN_RESET && left_min_ff <= ssp_pkg::MIN_RESET &&
      right_min_ff <= ssp_pkg::MIN_RESET)
      else $error("sector minimum above empty value");

endmodule

[rtl/scan_sector_proximity_classifier.sv]
// ----------------------------------------------------------------------------
// scan_sector_proximity_classifier
// Streams observation elements and emits eight motion and proximity flags
// for each observation.
// ----------------------------------------------------------------------------
// One element is taken every clock cycle while the input does not stall. An
// element passes an input register; if it is marked last, its flags are then
// registered in the result register, which offers them. The input stalls
// only while a last element waits for a result that has not yet been taken.
// Ray elements update the front, left and right minima as 100x scaled ranges;
// elements 78, 79, 82 and 83 latch the goal vector and speeds, and these stay
// until rewritten. Minima return to empty after each result. Thresholds are
// to be written through the csr port only while idle; this is not enforced.
// ----------------------------------------------------------------------------
module scan_sector_proximity_classifier (
   input  logic                            clock,
   input  logic                            reset,
   ssp_req_if.sink                         req,
   ssp_rsp_if.source                       rsp,
   input  logic                            csr_write_enable,
   input  logic [ssp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ssp_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   ssp_pkg::cfg_type   cfg;
   ssp_pkg::stage_type stage;
   logic               stage_valid;
   logic               stage_ready;

   ssp_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   ssp_input_stage u_input (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .stage_ready (stage_ready),
      .stage_valid (stage_valid),
      .stage       (stage)
   );

   ssp_classify u_classify (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .stage_valid (stage_valid),
      .stage       (stage),
      .stage_ready (stage_ready),
      .rsp         (rsp)
   );

endmodule
